// ----- rtl/csrm_pkg.sv -----
// Shared types, codes and widths for the byte-entry store with remove-matching.
package csrm_pkg;

    localparam int unsigned CMD_W         = 3;
    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned STATUS_W      = 2;
    localparam int unsigned COUNT_W       = 6;
    localparam int unsigned DEPTH_DEFAULT = 32;
    localparam int unsigned QUEUE_DEPTH   = 2;

    // Command codes as they arrive on the input channel.
    localparam logic [CMD_W-1:0] CMD_PUSH       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE     = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ_NEWEST = 3'd2;
    localparam logic [CMD_W-1:0] CMD_READ_OLDEST = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR      = 3'd4;

    // Status codes of a result item.
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

    typedef enum logic [2:0] {
        OP_PUSH,
        OP_REMOVE,
        OP_READ_NEWEST,
        OP_READ_OLDEST,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] value;
    } t_op_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   byte_out;
        logic [COUNT_W-1:0]  removed_count;
        logic                last;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REMOVE,
        S_READ,
        S_RESULT
    } t_state;

endpackage

// ----- rtl/csrm_if.sv -----
// Valid/ready channel interfaces for command items and result items.
interface csrm_cmd_if;
    logic                         valid;
    logic                         ready;
    logic [csrm_pkg::CMD_W-1:0]   command;
    logic [csrm_pkg::BYTE_W-1:0]  byte_value;

    modport source (output valid, output command, output byte_value, input ready);
    modport sink   (input valid, input command, input byte_value, output ready);
endinterface

interface csrm_res_if;
    logic                          valid;
    logic                          ready;
    logic [csrm_pkg::STATUS_W-1:0] status;
    logic [csrm_pkg::BYTE_W-1:0]   byte_out;
    logic [csrm_pkg::COUNT_W-1:0]  removed_count;
    logic                          last;

    modport source (output valid, output status, output byte_out, output removed_count,
                    output last, input ready);
    modport sink   (input valid, input status, input byte_out, input removed_count,
                    input last, output ready);
endinterface

// ----- rtl/char_stack_remove_matching_top.sv -----
// Top level of the bounded byte-entry store with push, remove-matching, read-out and clear.
//
// This block keeps up to DEPTH byte entries in push order, and takes one command per
// input item: push, remove every entry equal to a key, read out newest first, read out
// oldest first, or clear. Push, clear and a read-out of an empty store give one result
// each. A remove walks the held entries through the entry memory's single read port,
// one entry per cycle, and gives its one result once the walk is done. A read-out
// streams one result per entry, one per cycle while the output is taken; the last
// result of every command has last set. Unknown command codes are taken and dropped
// without a result. The entry memory is not cleared after reset, and no start-up pass
// is needed: only entries below the current count are ever read.
module char_stack_remove_matching_top #(
    parameter int unsigned DEPTH = csrm_pkg::DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csrm_cmd_if.sink   i_cmd,
    csrm_res_if.source o_res
);
    import csrm_pkg::*;

    // Decoded commands flow from the front end into a short queue, so the front end
    // keeps taking items while the back end is busy walking the memory, until the queue is full.
    logic     front_push;
    t_op_item front_item;
    logic     queue_full;
    logic     queue_valid;
    t_op_item queue_item;
    logic     back_pop;

    csrm_front u_front (
        .i_cmd  (i_cmd),
        .i_full (queue_full),
        .o_push (front_push),
        .o_item (front_item)
    );

    csrm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .i_pop   (back_pop),
        .o_item  (queue_item)
    );

    // The back end owns the entry memory and the count, and drives the result
    // channel from its own output register.
    csrm_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .i_item  (queue_item),
        .o_pop   (back_pop),
        .o_res   (o_res)
    );

endmodule

// ----- rtl/csrm_front.sv -----
// Front end: accepts command items and decodes them into queue entries.
module csrm_front (
    csrm_cmd_if.sink           i_cmd,
    input  logic               i_full,
    output logic               o_push,
    output csrm_pkg::t_op_item o_item
);
    import csrm_pkg::*;

    logic known;

    assign i_cmd.ready = !i_full;

    always_comb begin
        known        = 1'b1;
        o_item.op    = OP_PUSH;
        o_item.value = i_cmd.byte_value;
        unique case (i_cmd.command)
            CMD_PUSH:        o_item.op = OP_PUSH;
            CMD_REMOVE:      o_item.op = OP_REMOVE;
            CMD_READ_NEWEST: o_item.op = OP_READ_NEWEST;
            CMD_READ_OLDEST: o_item.op = OP_READ_OLDEST;
            CMD_CLEAR:       o_item.op = OP_CLEAR;
            default:         known     = 1'b0;
        endcase
    end

    // Unknown commands are taken and dropped; they cause no result.
    assign o_push = i_cmd.valid && !i_full && known;

endmodule

// ----- rtl/csrm_queue.sv -----
// Short queue of decoded commands between the front end and the back end.
module csrm_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  csrm_pkg::t_op_item i_item,
    output logic               o_full,
    output logic               o_valid,
    input  logic               i_pop,
    output csrm_pkg::t_op_item o_item
);
    import csrm_pkg::*;

    localparam int unsigned QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QAW-1:0] LAST_PTR = QAW'(QUEUE_DEPTH - 1);
    localparam logic [QCW-1:0] FULL_FILL = QCW'(QUEUE_DEPTH);

    t_op_item       r_slot [QUEUE_DEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QCW-1:0] r_fill;

    assign o_full  = (r_fill == FULL_FILL);
    assign o_valid = (r_fill != '0);
    assign o_item  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + QAW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + QAW'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + QCW'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - QCW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

// ----- rtl/csrm_back.sv -----
// Back end: entry memory, walking sequencer and registered result output.
module csrm_back #(
    parameter int unsigned DEPTH = csrm_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  csrm_pkg::t_op_item i_item,
    output logic               o_pop,
    csrm_res_if.source         o_res
);
    import csrm_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [BYTE_W-1:0]   r_mem [DEPTH];

    t_state              r_state;
    t_state              n_state;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_kept;
    logic                r_pend;
    t_op                 r_op;
    logic [BYTE_W-1:0]   r_key;
    logic [BYTE_W-1:0]   r_rdata;
    logic [STATUS_W-1:0] r_res_status;
    logic [COUNT_W-1:0]  r_res_removed;
    logic                r_out_vld;
    t_result             r_out;

    logic                slot_free;
    logic                more;
    logic                is_full;
    logic [CW-1:0]       newest_slot;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [BYTE_W-1:0]   wr_data;
    logic                emit;
    logic                res_load;

    assign slot_free   = !r_out_vld || o_res.ready;
    assign more        = (r_idx < r_count);
    assign is_full     = (r_count >= FULL_COUNT);
    assign newest_slot = r_count - r_idx - CW'(1);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_item.op)
                        OP_REMOVE:      n_state = S_REMOVE;
                        OP_READ_NEWEST,
                        OP_READ_OLDEST: n_state = (r_count == '0) ? S_RESULT : S_READ;
                        default:        n_state = S_RESULT;
                    endcase
                end
            end
            S_REMOVE: begin
                if (!more && !r_pend) begin
                    n_state = S_RESULT;
                end
            end
            S_READ: begin
                if (emit && (r_idx == r_count)) begin
                    n_state = S_IDLE;
                end
            end
            S_RESULT: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    // Datapath controls.
    always_comb begin
        o_pop    = 1'b0;
        rd_en    = 1'b0;
        rd_addr  = r_idx[AW-1:0];
        wr_en    = 1'b0;
        wr_addr  = r_count[AW-1:0];
        wr_data  = i_item.value;
        emit     = 1'b0;
        res_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_pop = i_valid;
                wr_en = i_valid && (i_item.op == OP_PUSH) && !is_full;
            end
            S_REMOVE: begin
                rd_en   = more;
                wr_addr = r_kept[AW-1:0];
                wr_data = r_rdata;
                wr_en   = r_pend && (r_rdata != r_key);
            end
            S_READ: begin
                emit  = r_pend && slot_free;
                rd_en = more && (!r_pend || emit);
                if (r_op == OP_READ_NEWEST) begin
                    rd_addr = newest_slot[AW-1:0];
                end
            end
            S_RESULT: begin
                res_load = slot_free;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit || res_load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
            if (rd_en) begin
                r_pend <= 1'b1;
            end else if ((r_state == S_REMOVE) || emit) begin
                r_pend <= 1'b0;
            end
            if (r_state == S_IDLE && i_valid) begin
                if (wr_en) begin
                    r_count <= r_count + CW'(1);
                end else if (i_item.op == OP_CLEAR) begin
                    r_count <= '0;
                end
            end else if (r_state == S_REMOVE && !more && !r_pend) begin
                r_count <= r_kept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_op          <= i_item.op;
            r_key         <= i_item.value;
            r_idx         <= '0;
            r_kept        <= '0;
            r_res_removed <= '0;
            unique case (i_item.op)
                OP_PUSH:        r_res_status <= is_full ? ST_FULL : ST_OK;
                OP_READ_NEWEST,
                OP_READ_OLDEST: r_res_status <= ST_EMPTY;
                default:        r_res_status <= ST_OK;
            endcase
        end else begin
            if (rd_en) begin
                r_idx <= r_idx + CW'(1);
            end
            if (r_state == S_REMOVE && wr_en) begin
                r_kept <= r_kept + CW'(1);
            end
            if (r_state == S_REMOVE && !more && !r_pend) begin
                r_res_status  <= (r_kept == r_count) ? ST_NOT_FOUND : ST_OK;
                r_res_removed <= COUNT_W'(r_count - r_kept);
            end
        end
        if (emit) begin
            r_out.status        <= ST_OK;
            r_out.byte_out      <= r_rdata;
            r_out.removed_count <= '0;
            r_out.last          <= (r_idx == r_count);
        end else if (res_load) begin
            r_out.status        <= r_res_status;
            r_out.byte_out      <= '0;
            r_out.removed_count <= r_res_removed;
            r_out.last          <= 1'b1;
        end
    end

    assign o_res.valid         = r_out_vld;
    assign o_res.status        = r_out.status;
    assign o_res.byte_out      = r_out.byte_out;
    assign o_res.removed_count = r_out.removed_count;
    assign o_res.last          = r_out.last;

endmodule

// ----- rtl/csrm_checker.sv -----
// Port-level assertions for the store's result channel, bound to the top level.
module csrm_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          i_ready,
    input logic [csrm_pkg::STATUS_W-1:0] i_status,
    input logic [csrm_pkg::BYTE_W-1:0]   i_byte_out,
    input logic [csrm_pkg::COUNT_W-1:0]  i_removed_count,
    input logic                          i_last
);
    import csrm_pkg::*;

    // No result item may be offered in the cycle after reset.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result offered right after reset");

    a_hold_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid &&
            $stable({i_status, i_byte_out, i_removed_count, i_last}))
        else $error("stalled result item changed or vanished");

    // Any non-ok status is a single, final result without data.
    a_error_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_status != ST_OK) |->
            i_last && (i_byte_out == '0) && (i_removed_count == '0))
        else $error("error result is not a lone final item");

    // A removal count comes only in the one ok result of a remove.
    a_count_is_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_removed_count != '0) |->
            (i_status == ST_OK) && i_last && (i_byte_out == '0))
        else $error("removal count on a result that is not a remove result");

endmodule

bind char_stack_remove_matching_top csrm_checker u_csrm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (o_res.valid),
    .i_ready         (o_res.ready),
    .i_status        (o_res.status),
    .i_byte_out      (o_res.byte_out),
    .i_removed_count (o_res.removed_count),
    .i_last          (o_res.last)
);
